@@ rtl/core/rffd_pkg.sv @@
package rffd_pkg;

  localparam int CACHE_ENTRIES_DEF = 10;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 80;

  typedef enum logic [3:0] {
    PH_LEN,
    PH_FCF0,
    PH_FCF1,
    PH_SEQ,
    PH_DISCARD,
    PH_PAN0,
    PH_PAN1,
    PH_DST0,
    PH_DST1,
    PH_SRC0,
    PH_SRC1,
    PH_PAYLOAD,
    PH_TRAIL0,
    PH_TRAIL1
  } phase_t;

  localparam logic [2:0] ST_DELIVERED = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT = 3'd1;
  localparam logic [2:0] ST_ACK       = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_NO_BUFFER = 3'd5;
  localparam logic [2:0] ST_DUPLICATE = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_BCAST_ADDR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAY    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEDUP_EN   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_EN     = 2'd3;

  localparam logic [15:0] BCAST_RESET   = 16'hFFFF;
  localparam logic [6:0]  MAX_PAY_RESET = 7'd116;
  localparam logic [7:0]  ACKED_RESET   = 8'hFF;
  localparam logic [15:0] ACK_FCF       = 16'h0002;

  typedef struct packed {
    logic [15:0] src;
    logic [7:0]  seq;
  } cache_key_t;

  localparam cache_key_t CACHE_EMPTY = '{src: 16'hFFFF, seq: 8'hFF};

  typedef struct packed {
    logic       insert;
    cache_key_t key;
  } cache_req_t;

  // result record, last field in the low bits
  typedef struct packed {
    logic [7:0]  dup_count;
    logic [7:0]  acked_seq;
    logic [6:0]  corr;
    logic        crc_ok;
    logic [7:0]  rssi;
    logic [6:0]  plen;
    logic [7:0]  seq;
    logic [15:0] src;
    logic [2:0]  status;
    logic [7:0]  payload;
  } record_t;

endpackage

@@ rtl/core/radio_rx_frame_filter_dedup.sv @@
// Channel   Dir  Handshake                       Content
// s_axis    in   s_axis_tvalid / s_axis_tready   FIFO byte or overflow command
// m_axis    out  m_axis_tvalid / m_axis_tready   payload byte or frame-end record
// cfg       in   cfg_valid / cfg_ready           register index and write data
//
// One input byte per cycle unless stalled; a result appears the next cycle.
// The duplicate lookup compares all cache cells in the same cycle as the
// second source byte, so lookup and insert both happen on that byte.
// A single result register sits on the output; s_axis_tready drops only
// while that register holds a record that m_axis does not take.
// Reset (rst, synchronous) clears the parser, loads the register defaults
// and fills every cache cell with the empty pair at once.
module radio_rx_frame_filter_dedup #(
  parameter int CACHE_ENTRIES = rffd_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] rx_byte, [8] buffer_ready, [15:9] zero
  input  logic [rffd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [0] command
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] payload_byte, [10:8] frame_status, [26:11] source_address,
  // [34:27] sequence_number, [41:35] payload_length, [49:42] rssi_value,
  // [50] crc_ok, [57:51] correlation, [65:58] last_acked_sequence,
  // [73:66] duplicate_count, [79:74] zero
  output logic [rffd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // [0] record_kind
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rffd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rffd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rffd_pkg::*;

  // configuration
  logic [15:0] bcast_addr;
  logic [6:0]  max_pay;
  logic        dedup_en;
  logic        ack_en;

  // parser
  phase_t      phase, phase_next;
  logic [6:0]  bytes_left, bytes_left_next;
  logic [6:0]  frame_length, frame_length_next;
  logic [15:0] frame_control, frame_control_next;
  logic [7:0]  frame_sequence, frame_sequence_next;
  logic [15:0] dest_address, dest_address_next;
  logic [15:0] src_address, src_address_next;
  logic [2:0]  pending_status, pending_status_next;
  logic [7:0]  rssi_byte, rssi_byte_next;
  logic [7:0]  acked_seq, acked_seq_next;
  logic [7:0]  dup_counter, dup_counter_next;

  // output register
  logic        out_valid;
  logic        out_kind;
  record_t     out_rec;

  logic        accept;
  logic        cmd;
  logic [7:0]  rx_byte;
  logic        buf_ready;

  logic        emit;
  logic        emit_kind;
  record_t     emit_rec;

  logic [6:0]  rem;
  logic [6:0]  left_dec;
  cache_req_t  cache_req;
  logic        cache_hit;

  assign cmd       = s_axis_tuser;
  assign rx_byte   = s_axis_tdata[7:0];
  assign buf_ready = s_axis_tdata[8];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign rem      = frame_length - 7'd3;
  assign left_dec = (bytes_left != 7'd0) ? bytes_left - 7'd1 : 7'd0;

  assign cache_req.key.src = {src_address[15:8], rx_byte};
  assign cache_req.key.seq = frame_sequence;
  assign cache_req.insert  = accept && (cmd == CMD_DATA) && (phase == PH_SRC1) &&
                             buf_ready && dedup_en && (dest_address != bcast_addr) &&
                             !cache_hit;

  rffd_cache #(
    .ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk (clk),
    .rst (rst),
    .req (cache_req),
    .hit (cache_hit)
  );

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    frame_length_next   = frame_length;
    frame_control_next  = frame_control;
    frame_sequence_next = frame_sequence;
    dest_address_next   = dest_address;
    src_address_next    = src_address;
    pending_status_next = pending_status;
    rssi_byte_next      = rssi_byte;
    acked_seq_next      = acked_seq;
    dup_counter_next    = dup_counter;
    emit                = 1'b0;
    emit_kind           = KIND_END;
    emit_rec            = '0;
    emit_rec.acked_seq  = acked_seq;
    emit_rec.dup_count  = dup_counter;

    if (accept) begin
      if (cmd == CMD_FLUSH) begin
        phase_next      = PH_LEN;
        bytes_left_next = 7'd0;
        emit            = 1'b1;
        emit_rec.status = ST_OVERFLOW;
      end else begin
        case (phase)
          PH_FCF0: begin
            frame_control_next = {8'd0, rx_byte};
            phase_next         = PH_FCF1;
          end
          PH_FCF1: begin
            frame_control_next = {rx_byte, frame_control[7:0]};
            phase_next         = PH_SEQ;
          end
          PH_SEQ: begin
            frame_sequence_next = rx_byte;
            bytes_left_next     = rem;
            phase_next          = PH_DISCARD;
            if (rem == 7'd2) begin
              if (frame_control == ACK_FCF && ack_en) begin
                acked_seq_next = rx_byte;
              end
              pending_status_next = ST_ACK;
            end else if (rem < 7'd9) begin
              pending_status_next = ST_SHORT;
            end else if (rem - 7'd9 > max_pay) begin
              pending_status_next = ST_TOO_LONG;
            end else begin
              bytes_left_next = bytes_left;
              phase_next      = PH_PAN0;
            end
          end
          PH_DISCARD: begin
            bytes_left_next = left_dec;
            if (left_dec == 7'd0) begin
              phase_next      = PH_LEN;
              emit            = 1'b1;
              emit_rec.status = pending_status;
              emit_rec.src    = (pending_status >= ST_NO_BUFFER) ? src_address : 16'd0;
              emit_rec.seq    = (pending_status >= ST_ACK) ? frame_sequence : 8'd0;
            end
          end
          PH_PAN0: phase_next = PH_PAN1;
          PH_PAN1: phase_next = PH_DST0;
          PH_DST0: begin
            dest_address_next = {8'd0, rx_byte};
            phase_next        = PH_DST1;
          end
          PH_DST1: begin
            dest_address_next = {rx_byte, dest_address[7:0]};
            phase_next        = PH_SRC0;
          end
          PH_SRC0: begin
            src_address_next = {rx_byte, 8'd0};
            phase_next       = PH_SRC1;
          end
          PH_SRC1: begin
            src_address_next = {src_address[15:8], rx_byte};
            if (!buf_ready) begin
              pending_status_next = ST_NO_BUFFER;
              bytes_left_next     = rem - 7'd6;
              phase_next          = PH_DISCARD;
            end else if (dedup_en && dest_address != bcast_addr && cache_hit) begin
              dup_counter_next    = dup_counter + 8'd1;
              pending_status_next = ST_DUPLICATE;
              bytes_left_next     = rem - 7'd6;
              phase_next          = PH_DISCARD;
            end else begin
              bytes_left_next = rem - 7'd8;
              phase_next      = (rem == 7'd8) ? PH_TRAIL0 : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            emit             = 1'b1;
            emit_kind        = KIND_PAYLOAD;
            emit_rec         = '0;
            emit_rec.payload = rx_byte;
            bytes_left_next  = left_dec;
            if (left_dec == 7'd0) begin
              phase_next = PH_TRAIL0;
            end
          end
          PH_TRAIL0: begin
            rssi_byte_next = rx_byte;
            phase_next     = PH_TRAIL1;
          end
          PH_TRAIL1: begin
            phase_next      = PH_LEN;
            emit            = 1'b1;
            emit_rec.status = ST_DELIVERED;
            emit_rec.src    = src_address;
            emit_rec.seq    = frame_sequence;
            emit_rec.plen   = frame_length - 7'd11;
            emit_rec.rssi   = rssi_byte;
            emit_rec.crc_ok = rx_byte[7];
            emit_rec.corr   = rx_byte[6:0];
          end
          default: begin
            // length byte; a length of zero ends the frame right here
            frame_length_next = rx_byte[6:0];
            if (rx_byte[6:0] < 7'd5) begin
              pending_status_next = ST_TOO_SHORT;
              if (rx_byte[6:0] == 7'd0) begin
                bytes_left_next = 7'd0;
                phase_next      = PH_LEN;
                emit            = 1'b1;
                emit_rec.status = ST_TOO_SHORT;
              end else begin
                bytes_left_next = rx_byte[6:0];
                phase_next      = PH_DISCARD;
              end
            end else begin
              phase_next = PH_FCF0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN;
      bytes_left     <= 7'd0;
      frame_length   <= 7'd0;
      frame_control  <= 16'd0;
      frame_sequence <= 8'd0;
      dest_address   <= 16'd0;
      src_address    <= 16'd0;
      pending_status <= ST_DELIVERED;
      rssi_byte      <= 8'd0;
      acked_seq      <= ACKED_RESET;
      dup_counter    <= 8'd0;
    end else begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      frame_length   <= frame_length_next;
      frame_control  <= frame_control_next;
      frame_sequence <= frame_sequence_next;
      dest_address   <= dest_address_next;
      src_address    <= src_address_next;
      pending_status <= pending_status_next;
      rssi_byte      <= rssi_byte_next;
      acked_seq      <= acked_seq_next;
      dup_counter    <= dup_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcast_addr <= BCAST_RESET;
      max_pay    <= MAX_PAY_RESET;
      dedup_en   <= 1'b1;
      ack_en     <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BCAST_ADDR: bcast_addr <= cfg_data;
        CFG_MAX_PAY:    max_pay    <= cfg_data[6:0];
        CFG_DEDUP_EN:   dedup_en   <= cfg_data[0];
        CFG_ACK_EN:     ack_en     <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind <= emit_kind;
      out_rec  <= emit_rec;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {{(M_TDATA_W - $bits(record_t)){1'b0}}, out_rec};

endmodule

@@ rtl/core/rffd_cell.sv @@
module rffd_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  rffd_pkg::cache_key_t key_in,
  input  rffd_pkg::cache_key_t probe,
  output rffd_pkg::cache_key_t key_out,
  output logic                 match
);
  import rffd_pkg::*;

  cache_key_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= CACHE_EMPTY;
    end else if (shift) begin
      entry <= key_in;
    end
  end

  assign key_out = entry;
  assign match   = (entry == probe);

endmodule

@@ rtl/core/rffd_cache.sv @@
// Newest pair enters cell 0, every insert moves the row by one cell and the
// oldest pair drops off the end: the same set as a ring with a write pointer.
module rffd_cache #(
  parameter int ENTRIES = rffd_pkg::CACHE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rffd_pkg::cache_req_t req,
  output logic                 hit
);
  import rffd_pkg::*;

  cache_key_t         chain [ENTRIES];
  logic [ENTRIES-1:0] match;

  assign chain[0] = req.key;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i < ENTRIES - 1) begin : g_mid
      rffd_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (req.insert),
        .key_in  (chain[i]),
        .probe   (req.key),
        .key_out (chain[i+1]),
        .match   (match[i])
      );
    end else begin : g_last
      rffd_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .shift   (req.insert),
        .key_in  (chain[i]),
        .probe   (req.key),
        .key_out (),
        .match   (match[i])
      );
    end
  end

  assign hit = |match;

endmodule
